// ===== src/cfl_pkg.sv =====
package cfl_pkg;

   // field widths
   localparam int DIR_BITS = 16;
   localparam int TEX_BITS = 16;
   localparam int NUM_BITS = DIR_BITS + 1;
   localparam int REM_BITS = DIR_BITS + TEX_BITS + 1;
   localparam int NUM_FACES = 6;
   localparam logic [TEX_BITS-1:0] TEX_ONE = TEX_BITS'(1) << (TEX_BITS - 1);

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      FACE_FRONT  = 3'd0,
      FACE_BACK   = 3'd1,
      FACE_LEFT   = 3'd2,
      FACE_RIGHT  = 3'd3,
      FACE_TOP    = 3'd4,
      FACE_BOTTOM = 3'd5
   } face_type;

   // per-face geometry, in the order faces are tried
   localparam face_type FACE_CODE [NUM_FACES] =
      '{FACE_FRONT, FACE_BACK, FACE_LEFT, FACE_RIGHT, FACE_TOP, FACE_BOTTOM};
   localparam logic [1:0] FACE_AXIS [NUM_FACES] =
      '{AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y, AXIS_Y};
   localparam logic FACE_POS [NUM_FACES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
   localparam logic [1:0] U_AXIS [NUM_FACES] =
      '{AXIS_X, AXIS_X, AXIS_Z, AXIS_Z, AXIS_X, AXIS_X};
   localparam logic U_POS [NUM_FACES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
   localparam logic [1:0] V_AXIS [NUM_FACES] =
      '{AXIS_Y, AXIS_Y, AXIS_Y, AXIS_Y, AXIS_Z, AXIS_Z};
   localparam logic V_POS [NUM_FACES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

   typedef struct packed {
      logic signed [DIR_BITS-1:0] dir_x;
      logic signed [DIR_BITS-1:0] dir_y;
      logic signed [DIR_BITS-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic                hit;
      face_type            face;
      logic [TEX_BITS-1:0] tex_u;
      logic [TEX_BITS-1:0] tex_v;
   } rsp_type;

   // classified item between front and back
   typedef struct packed {
      logic                hit;
      face_type            face;
      logic [DIR_BITS-1:0] m;
      logic [NUM_BITS-1:0] num_u;
      logic [NUM_BITS-1:0] num_v;
   } mid_type;

endpackage

// ===== src/cubemap_face_uv_lookup.sv =====
// channel  direction  ports                         transfer when
// req      in         req_push, req_full, req_data  req_push && !req_full
// rsp      out        rsp_pop, rsp_empty, rsp_data  rsp_pop && !rsp_empty
//
// one direction per cycle sustained while results are taken; a req transfer
// passes through the queue, the stage 0 register and the divider stages,
// one quotient bit per stage for u and v in parallel, before the result shows.
// reset (synchronous) empties the two-entry queue and the divider pipeline.
// a held result stalls the divider; the queue in front keeps taking
// directions until both of its entries are filled.
module cubemap_face_uv_lookup (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cfl_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cfl_pkg::rsp_type rsp_data
);
   import cfl_pkg::*;

   mid_type cls, mid_head;
   logic mid_empty, mid_pop;

   // classify the direction
   cfl_front u_front (
      .req (req_data),
      .mid (cls)
   );

   // decoupling queue
   cfl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls),
      .full      (req_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .pop_data  (mid_head)
   );

   // texcoord division
   cfl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_head),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // a miss carries no face or coordinates
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.hit) |->
         (rsp_data.face == FACE_FRONT && rsp_data.tex_u == '0 && rsp_data.tex_v == '0))
      else $error("miss with nonzero fields");

   // coordinates never exceed one
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.tex_u <= TEX_ONE && rsp_data.tex_v <= TEX_ONE))
      else $error("texcoord above one");

   // nothing waits straight after reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (rsp_empty && !req_full))
      else $error("not empty after reset");

endmodule

// ===== src/cfl_front.sv =====
module cfl_front (
   input  cfl_pkg::req_type req,
   output cfl_pkg::mid_type mid
);
   import cfl_pkg::*;

   logic signed [DIR_BITS-1:0] d [3];
   logic [DIR_BITS-1:0] mg [3];
   logic cand [NUM_FACES];
   logic found;
   logic [2:0] sel;
   logic signed [NUM_BITS:0] cu, cv, nu, nv;

   // magnitudes of the three components
   always_comb begin
      d[0] = req.dir_x;
      d[1] = req.dir_y;
      d[2] = req.dir_z;
      for (int a = 0; a < 3; a++) begin
         mg[a] = d[a][DIR_BITS-1] ? DIR_BITS'(-d[a]) : DIR_BITS'(d[a]);
      end
   end

   // per-face hit test, then first face in order wins
   always_comb begin
      found = 1'b0;
      sel = '0;
      for (int f = 0; f < NUM_FACES; f++) begin
         cand[f] = (d[FACE_AXIS[f]] != '0)
                && (d[FACE_AXIS[f]][DIR_BITS-1] == !FACE_POS[f])
                && (mg[U_AXIS[f]] <= mg[FACE_AXIS[f]])
                && (mg[V_AXIS[f]] <= mg[FACE_AXIS[f]]);
      end
      for (int f = NUM_FACES - 1; f >= 0; f--) begin
         if (cand[f]) begin
            found = 1'b1;
            sel = 3'(f);
         end
      end
   end

   // numerators m +/- c, never negative on a hit
   always_comb begin
      cu = (NUM_BITS+1)'(d[U_AXIS[sel]]);
      cv = (NUM_BITS+1)'(d[V_AXIS[sel]]);
      nu = $signed({2'b00, mg[FACE_AXIS[sel]]}) + (U_POS[sel] ? cu : -cu);
      nv = $signed({2'b00, mg[FACE_AXIS[sel]]}) + (V_POS[sel] ? cv : -cv);
      mid.hit = found;
      mid.face = found ? FACE_CODE[sel] : FACE_FRONT;
      mid.m = mg[FACE_AXIS[sel]];
      mid.num_u = NUM_BITS'(nu);
      mid.num_v = NUM_BITS'(nv);
   end

endmodule

// ===== src/cfl_queue.sv =====
module cfl_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfl_pkg::mid_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output cfl_pkg::mid_type pop_data
);
   import cfl_pkg::*;

   mid_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/cfl_back.sv =====
module cfl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   input  cfl_pkg::mid_type mid_data,
   output logic             mid_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cfl_pkg::rsp_type rsp_data
);
   import cfl_pkg::*;

   localparam int STAGES = TEX_BITS;

   logic                valid_ff [STAGES+1];
   logic                hit_ff   [STAGES+1];
   face_type            face_ff  [STAGES+1];
   logic [DIR_BITS:0]   d_ff     [STAGES+1];
   logic [REM_BITS-1:0] ru_ff    [STAGES+1];
   logic [REM_BITS-1:0] rv_ff    [STAGES+1];
   logic [TEX_BITS-1:0] qu_ff    [STAGES+1];
   logic [TEX_BITS-1:0] qv_ff    [STAGES+1];
   logic advance;

   // the whole divider moves when the last stage is free or taken
   assign advance = !valid_ff[STAGES] || rsp_pop;
   assign mid_pop = advance && !mid_empty;
   assign rsp_empty = !valid_ff[STAGES];

   // stage 0: dividend num*2^(T-1) + m, divisor 2m
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= !mid_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff[0] <= mid_data.hit;
         face_ff[0] <= mid_data.face;
         d_ff[0] <= {mid_data.m, 1'b0};
         ru_ff[0] <= (REM_BITS'(mid_data.num_u) << (TEX_BITS - 1)) + REM_BITS'(mid_data.m);
         rv_ff[0] <= (REM_BITS'(mid_data.num_v) << (TEX_BITS - 1)) + REM_BITS'(mid_data.m);
         qu_ff[0] <= '0;
         qv_ff[0] <= '0;
      end
   end

   // one restoring quotient bit per stage, both coordinates side by side
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int SH = STAGES - 1 - k;
      logic [REM_BITS-1:0] ds;
      logic ge_u, ge_v;

      always_comb begin
         ds = REM_BITS'(d_ff[k]) << SH;
         ge_u = (ru_ff[k] >= ds);
         ge_v = (rv_ff[k] >= ds);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            hit_ff[k+1] <= hit_ff[k];
            face_ff[k+1] <= face_ff[k];
            d_ff[k+1] <= d_ff[k];
            ru_ff[k+1] <= ge_u ? ru_ff[k] - ds : ru_ff[k];
            rv_ff[k+1] <= ge_v ? rv_ff[k] - ds : rv_ff[k];
            qu_ff[k+1] <= qu_ff[k] | (TEX_BITS'(ge_u) << SH);
            qv_ff[k+1] <= qv_ff[k] | (TEX_BITS'(ge_v) << SH);
         end
      end
   end

   // saturate and blank a miss
   always_comb begin
      rsp_data.hit = hit_ff[STAGES];
      rsp_data.face = hit_ff[STAGES] ? face_ff[STAGES] : FACE_FRONT;
      rsp_data.tex_u = !hit_ff[STAGES] ? '0
                     : (qu_ff[STAGES] > TEX_ONE) ? TEX_ONE : qu_ff[STAGES];
      rsp_data.tex_v = !hit_ff[STAGES] ? '0
                     : (qv_ff[STAGES] > TEX_ONE) ? TEX_ONE : qv_ff[STAGES];
   end

   // ru/rv of the last stage hold the remainders, unused past here
   logic unused_rem;
   assign unused_rem = ^{ru_ff[STAGES], rv_ff[STAGES], d_ff[STAGES]};

endmodule

// ===== bench/cubemap_face_uv_lookup_test.sv =====
module cubemap_face_uv_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cfl_pkg::*;

   localparam int LATENCY = TEX_BITS + 1;
   localparam int RANDOM_ITEMS = 1530;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   req_type pending_dirs[$];
   rsp_type expected_lookups[$];
   int      fail_count = 0;
   int      hits_seen = 0;
   int      misses_seen = 0;
   int      lookups_checked = 0;
   longint  cycle_count = 0;
   bit      stimulus_done = 1'b0;
   bit      no_idling = 1'b0;
   bit      req_taken = 1'b0;
   int      send_gap = 0;
   int      pop_gap = 0;
   int      hold_off = 0;

   cubemap_face_uv_lookup uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // rounded q1.15 value of (m + s*c) / 2m, saturated at one
   function automatic logic [TEX_BITS-1:0] face_coord(longint c, bit pos, longint m);
      longint num;
      longint q;
      num = pos ? m + c : m - c;
      q = ((longint'(1) << (TEX_BITS - 1)) * num + m) / (2 * m);
      if (q > (longint'(1) << (TEX_BITS - 1)))
         q = longint'(1) << (TEX_BITS - 1);
      return q[TEX_BITS-1:0];
   endfunction

   // first face in trial order whose closed square holds the crossing point
   function automatic rsp_type lookup_face(req_type d);
      longint comp[3];
      longint major;
      longint m;
      longint cu;
      longint cv;
      rsp_type r;
      comp[0] = d.dir_x;
      comp[1] = d.dir_y;
      comp[2] = d.dir_z;
      r = '0;
      for (int f = 0; f < NUM_FACES; f++) begin
         major = comp[FACE_AXIS[f]];
         if (major == 0) continue;
         if ((major > 0) != FACE_POS[f]) continue;
         m = major < 0 ? -major : major;
         cu = comp[U_AXIS[f]];
         cv = comp[V_AXIS[f]];
         if ((cu < 0 ? -cu : cu) > m || (cv < 0 ? -cv : cv) > m) continue;
         r.hit = 1'b1;
         r.face = FACE_CODE[f];
         r.tex_u = face_coord(cu, U_POS[f], m);
         r.tex_v = face_coord(cv, V_POS[f], m);
         return r;
      end
      return r;
   endfunction

   function automatic req_type make_dir(int x, int y, int z);
      req_type d;
      d.dir_x = x[DIR_BITS-1:0];
      d.dir_y = y[DIR_BITS-1:0];
      d.dir_z = z[DIR_BITS-1:0];
      return d;
   endfunction

   // random direction: a dominant axis with cross terms up to its size, ties, tiny, a zero or fully random
   function automatic req_type random_dir();
      int c[3];
      int a;
      int m;
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(65535) - 32768;
      case ($urandom_range(5))
         0, 1: begin
            a = $urandom_range(2);
            m = $urandom_range(32767, 1);
            c[a] = $urandom_range(1) ? m : -m;
            for (int i = 0; i < 3; i++)
               if (i != a) c[i] = $urandom_range(2 * m) - m;
         end
         2: begin
            // ties between axes land on edges and corners
            m = $urandom_range(32767, 1);
            for (int i = 0; i < 3; i++)
               if ($urandom_range(1)) c[i] = $urandom_range(1) ? m : -m;
         end
         3: begin
            for (int i = 0; i < 3; i++) c[i] = $urandom_range(6) - 3;
         end
         4: begin
            c[$urandom_range(2)] = 0;
         end
         default: ;
      endcase
      return make_dir(c[0], c[1], c[2]);
   endfunction

   // stimulus
   initial begin
      int ext[5];
      ext = '{-32768, 32767, 0, 1, -1};
      for (int i = 0; i < 5; i++) begin
         pending_dirs.push_back(make_dir(ext[i], 0, 0));
         pending_dirs.push_back(make_dir(0, ext[i], 0));
         pending_dirs.push_back(make_dir(0, 0, ext[i]));
      end
      pending_dirs.push_back(make_dir(100, 100, 100));
      pending_dirs.push_back(make_dir(-100, -100, -100));
      pending_dirs.push_back(make_dir(-32768, -32768, -32768));
      pending_dirs.push_back(make_dir(32767, -32768, 32767));
      pending_dirs.push_back(make_dir(5, 3, -32768));
      pending_dirs.push_back(make_dir(32767, 32767, -32768));
      pending_dirs.push_back(make_dir(-7, 32767, 7));
      pending_dirs.push_back(make_dir(3, 1, 2));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (pending_dirs.size() == 0);
      // pause until every directed lookup has come back
      wait (expected_lookups.size() == 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_dirs.push_back(random_dir());
         if (i == 300) hold_off = 120;
         if (i == RANDOM_ITEMS - 200) no_idling = 1'b1;
         if (pending_dirs.size() > 8) wait (pending_dirs.size() <= 8);
      end
      wait (pending_dirs.size() == 0);
      stimulus_done = 1'b1;
   end

   // request transfer as seen at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_push && !req_full;
   end

   // driver: changes on the falling edge, transfer decided at the rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_lookups.push_back(lookup_face(req_data));
            void'(pending_dirs.pop_front());
         end
         if (req_push && !req_taken) begin
            // keep offering the same item
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_push <= 1'b0;
         end else if (pending_dirs.size() > 0
                      && !(req_taken && !no_idling && $urandom_range(15) == 0)) begin
            req_push <= 1'b1;
            req_data <= pending_dirs[0];
         end else begin
            req_push <= 1'b0;
            if (!no_idling && pending_dirs.size() > 0) send_gap <= $urandom_range(11, 1) - 1;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap <= pop_gap - 1;
         rsp_pop <= 1'b0;
      end else if (!no_idling && $urandom_range(12) == 0) begin
         pop_gap <= $urandom_range(11, 1) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // monitor: check each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            fail_count <= fail_count + 1;
         end else begin
            want = expected_lookups.pop_front();
            lookups_checked <= lookups_checked + 1;
            if (want.hit) hits_seen <= hits_seen + 1;
            else misses_seen <= misses_seen + 1;
            if (rsp_data.hit !== want.hit || rsp_data.face !== want.face
                || rsp_data.tex_u !== want.tex_u || rsp_data.tex_v !== want.tex_v) begin
               $display("%0t: mismatch expected hit=%0b face=%0d u=%0d v=%0d", $time,
                        want.hit, want.face, want.tex_u, want.tex_v);
               $display("%0t:          actual   hit=%0b face=%0d u=%0d v=%0d", $time,
                        rsp_data.hit, rsp_data.face, rsp_data.tex_u, rsp_data.tex_v);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stimulus_done && expected_lookups.size() == 0);
      repeat (4 * LATENCY) @(posedge clock);
      @(negedge clock);
      $display("lookups checked: %0d (%0d hits, %0d misses)",
               lookups_checked, hits_seen, misses_seen);
      if (expected_lookups.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_lookups.size());
         fail_count = fail_count + 1;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_lookups.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

// ===== cubemap_face_uv_lookup.f =====
src/cfl_pkg.sv
src/cfl_front.sv
src/cfl_queue.sv
src/cfl_back.sv
src/cubemap_face_uv_lookup.sv
bench/cubemap_face_uv_lookup_test.sv
